@@ hw/rtl/base64_decoder_checked_defines.svh @@
// assertion macros for the base64 decoder
// used by the top level only, no other dependencies
`ifndef BASE64_DECODER_CHECKED_DEFINES_SVH
`define BASE64_DECODER_CHECKED_DEFINES_SVH

`ifndef ASSERT_OFF
`define B64_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) \
    else $error("%m: check failed");
`define B64_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define B64_ASSERT(lbl, clk, rst, prop)
`define B64_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/b64_pkg.sv @@
// shared types, constants and the alphabet lookup for the base64 decoder
// no dependencies
`timescale 1ns / 1ps

package b64_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_BAD_CHAR = 2'd2,
    ST_BAD_PAD  = 2'd3
  } b64_status_t;

  typedef struct packed {
    b64_status_t status;
    logic [1:0]  nbytes;
    logic [23:0] bits;
  } b64_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] val;
  } sextet_t;

  function automatic sextet_t b64_sextet(input logic [7:0] c);
    sextet_t s;
    s.valid = 1'b1;
    s.val   = 6'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      s.val = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.val = 6'd62;
    end else if (c == 8'h2F) begin
      s.val = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/base64_decoder_checked.sv @@
// Streaming base64 decoder (standard alphabet, '=' padding) with error status.
// One character is taken per cycle while in_stall is low; each fourth character completes a group
// that yields three, two or one bytes, the last marked by out_run_end, and an
// error yields a single result with a nonzero out_status and out_byte zero.
// The front end classifies each character in the cycle it arrives and writes
// finished groups and error records into a queue (QUEUE_DEPTH entries); the
// back end sends one byte per cycle from the head of that queue while
// out_stall is low. With no output stall the input runs at one character
// per cycle indefinitely. in_stall rises only when the queue is full because
// the output side stalls.
// depends on b64_pkg, b64_front, b64_queue, b64_back and the defines header
`timescale 1ns / 1ps
`include "base64_decoder_checked_defines.svh"

module base64_decoder_checked
  import b64_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_final_req,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic [1:0] out_status
);

  logic       in_accept;
  logic       push;
  logic       pop;
  b64_entry_t push_entry;
  b64_entry_t head;
  q_stat_t    q_stat;

  assign in_stall  = q_stat.full;
  assign in_accept = in_valid && !q_stat.full;

  b64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .char_in   (in_char_in),
    .final_req (in_final_req),
    .push      (push),
    .entry     (push_entry)
  );

  b64_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  b64_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .stat        (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_run_end (out_run_end),
    .out_status  (out_status)
  );

  // error records are single results with a zero byte
  `B64_ASSERT(a_err_single, clk, rst_n, (out_valid && out_status != ST_OK) |-> out_run_end)
  `B64_ASSERT(a_err_zero, clk, rst_n, (out_valid && out_status != ST_OK) |-> (out_byte == 8'd0))
  // a full queue always has something to send
  `B64_ASSERT(a_full_nonempty, clk, rst_n, in_stall |-> out_valid)
  // a group keeps going until its last byte is sent
  `B64_ASSERT_NXT(a_group_cont, clk, rst_n, out_valid && !out_stall && !out_run_end, out_valid)

endmodule

@@ hw/rtl/b64_front.sv @@
// front end: takes characters, tracks the group and classifies errors
// depends on b64_pkg
`timescale 1ns / 1ps

module b64_front
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_in,
  input  logic       final_req,
  output logic       push,
  output b64_entry_t entry
);

  logic [23:0] bits_r, bits_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [2:0]  pad_r, pad_nxt;
  logic        err_r, err_nxt;

  sextet_t     sx;
  logic        is_pad;
  logic [23:0] bits_sh;
  logic [23:0] grp_bits;
  logic [2:0]  grp_pad;

  always_comb begin
    sx       = b64_sextet(char_in);
    is_pad   = (char_in == PAD_CHAR);
    bits_sh  = {bits_r[17:0], 6'd0};
    grp_pad  = is_pad ? (pad_r + 3'd1) : pad_r;
    grp_bits = is_pad ? bits_sh : (bits_sh | {18'd0, sx.val});

    bits_nxt = bits_r;
    pos_nxt  = pos_r;
    pad_nxt  = pad_r;
    err_nxt  = err_r;
    push     = 1'b0;
    entry    = '{status: ST_OK, nbytes: 2'd1, bits: 24'd0};

    if (accept) begin
      if (err_r) begin
        if (final_req) begin
          bits_nxt = '0; pos_nxt = '0; pad_nxt = '0; err_nxt = 1'b0;
        end
      end else if (final_req && pos_r != 2'd3) begin
        push         = 1'b1;
        entry.status = ST_BAD_LEN;
        bits_nxt = '0; pos_nxt = '0; pad_nxt = '0; err_nxt = 1'b0;
      end else if (!is_pad && !(sx.valid && pad_r == 3'd0)) begin
        push         = 1'b1;
        entry.status = ST_BAD_CHAR;
        if (final_req) begin
          bits_nxt = '0; pos_nxt = '0; pad_nxt = '0; err_nxt = 1'b0;
        end else begin
          err_nxt = 1'b1;
        end
      end else if (pos_r != 2'd3) begin
        pos_nxt  = pos_r + 2'd1;
        pad_nxt  = grp_pad;
        bits_nxt = grp_bits;
      end else if (grp_pad > 3'd2 || (grp_pad != 3'd0 && !final_req)) begin
        push         = 1'b1;
        entry.status = ST_BAD_PAD;
        if (final_req) begin
          bits_nxt = '0; pos_nxt = '0; pad_nxt = '0; err_nxt = 1'b0;
        end else begin
          err_nxt = 1'b1;
        end
      end else begin
        push         = 1'b1;
        entry.nbytes = 2'd3 - grp_pad[1:0];
        entry.bits   = grp_bits;
        bits_nxt = '0; pos_nxt = '0; pad_nxt = '0; err_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      pos_r  <= '0;
      pad_r  <= '0;
      err_r  <= 1'b0;
    end else begin
      bits_r <= bits_nxt;
      pos_r  <= pos_nxt;
      pad_r  <= pad_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

@@ hw/rtl/b64_queue.sv @@
// small queue of decoded groups and error records between front and back
// depends on b64_pkg
`timescale 1ns / 1ps

module b64_queue
  import b64_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  b64_entry_t push_entry,
  input  logic       pop,
  output b64_entry_t head,
  output q_stat_t    stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b64_entry_t      mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
    stat.full  = (count_r == CW'(DEPTH));
    stat.empty = (count_r == '0);
    head       = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/b64_back.sv @@
// back end: sends the bytes of the head group one per transfer
// depends on b64_pkg
`timescale 1ns / 1ps

module b64_back
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  b64_entry_t head,
  input  q_stat_t    stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic [1:0] out_status
);

  logic [1:0] idx_r, idx_nxt;
  logic       last;
  logic       xfer;

  always_comb begin
    out_valid   = !stat.empty;
    last        = (idx_r == head.nbytes - 2'd1);
    xfer        = out_valid && !out_stall;
    pop         = xfer && last;
    out_run_end = last;
    out_status  = head.status;
    case (idx_r)
      2'd0:    out_byte = head.bits[23:16];
      2'd1:    out_byte = head.bits[15:8];
      2'd2:    out_byte = head.bits[7:0];
      default: out_byte = 8'd0;
    endcase
    idx_nxt = idx_r;
    if (xfer) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ dv/b64_decode_checker.sv @@
// checker for the base64 decoder: decodes each accepted character itself and
// compares every result transfer with the oldest decoded byte or status
// depends on b64_pkg for the status codes and the padding character
`timescale 1ns / 1ps

module b64_decode_checker
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_final_req,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_run_end,
  input  logic [1:0] out_status,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    b64_status_t status;
  } decoded_t;

  decoded_t    decoded_q[$];
  logic [23:0] group_bits_q;
  logic [1:0]  char_pos;
  logic [2:0]  pad_cnt;
  logic        in_error;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic clear_decoder();
    group_bits_q = 24'd0;
    char_pos     = 2'd0;
    pad_cnt      = 3'd0;
    in_error     = 1'b0;
  endtask

  task automatic queue_result(input decoded_t r);
    decoded_q = {decoded_q, r};
  endtask

  // {in alphabet, six-bit value}
  function automatic logic [6:0] sextet_of_char(input logic [7:0] ch);
    logic [6:0] r;
    r = 7'd0;
    if (ch >= "A" && ch <= "Z") begin
      r = {1'b1, 6'(ch - 8'd65)};
    end else if (ch >= "a" && ch <= "z") begin
      r = {1'b1, 6'(ch - 8'd71)};
    end else if (ch >= "0" && ch <= "9") begin
      r = {1'b1, 6'(ch + 8'd4)};
    end else if (ch == "+") begin
      r = {1'b1, 6'd62};
    end else if (ch == "/") begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  task automatic push_status(input b64_status_t code, input logic fin);
    decoded_t item;
    item.data   = 8'd0;
    item.last   = 1'b1;
    item.status = code;
    queue_result(item);
    if (fin) begin
      clear_decoder();
    end else begin
      in_error = 1'b1;
    end
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic fin);
    logic [6:0] sx;
    decoded_t   item;
    int         n;
    int         k;
    sx = sextet_of_char(ch);
    if (in_error) begin
      if (fin) clear_decoder();
    end else if (fin && char_pos != 2'd3) begin
      push_status(ST_BAD_LEN, fin);
    end else if (ch != PAD_CHAR && !(sx[6] && pad_cnt == 3'd0)) begin
      push_status(ST_BAD_CHAR, fin);
    end else begin
      if (ch == PAD_CHAR) begin
        pad_cnt      = pad_cnt + 3'd1;
        group_bits_q = {group_bits_q[17:0], 6'd0};
      end else begin
        group_bits_q = {group_bits_q[17:0], sx[5:0]};
      end
      if (char_pos != 2'd3) begin
        char_pos = char_pos + 2'd1;
      end else if (pad_cnt > 3'd2 || (pad_cnt != 3'd0 && !fin)) begin
        push_status(ST_BAD_PAD, fin);
      end else begin
        n = 3 - int'(pad_cnt);
        for (k = 0; k < n; k++) begin
          item.data   = 8'(group_bits_q >> (16 - 8 * k));
          item.last   = (k == n - 1);
          item.status = ST_OK;
          queue_result(item);
        end
        clear_decoder();
      end
    end
  endtask

  task automatic check_transfer();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transfer byte %02h end %0b status %0d",
                                out_byte, out_run_end, out_status));
    end else begin
      want = decoded_q.pop_front();
      if (out_byte !== want.data)
        report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
      if (out_run_end !== want.last)
        report_mismatch($sformatf("out_run_end %0b, expected %0b", out_run_end, want.last));
      if (out_status !== want.status)
        report_mismatch($sformatf("out_status %0d, expected %0d", out_status, want.status));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
      decoded_q.delete();
    end else begin
      if (in_valid && !in_stall) decode_char(in_char_in, in_final_req);
      if (out_valid && !out_stall) check_transfer();
    end
    pending = decoded_q.size();
  end

endmodule

@@ dv/testbench.sv @@
// top of the base64 decoder testbench: clock, reset, character texts and
// output stalls, with the verdict taken from b64_decode_checker
// depends on b64_pkg, base64_decoder_checked and b64_decode_checker
`timescale 1ns / 1ps

module testbench;
  import b64_pkg::*;

  localparam int TEXT_ITEMS  = 310;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in   = 8'd0;
  logic       in_final_req = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_end;
  logic [1:0] out_status;
  logic       hold_off     = 1'b0;
  logic       hold_go      = 1'b0;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int sent_count  = 0;
  int cycle_count = 0;
  int fail_count;
  int pending;

  string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  logic [7:0] text_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  base64_decoder_checked dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char_in  (in_char_in),
    .in_final_req(in_final_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_run_end (out_run_end),
    .out_status  (out_status)
  );

  b64_decode_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char_in  (in_char_in),
    .in_final_req(in_final_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_run_end (out_run_end),
    .out_status  (out_status),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off so the queue fills and the input side stalls
  initial begin
    wait (hold_go);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  task automatic set_phase(input idle_phase_t ph);
    case (ph)
      PH_FREE: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      PH_SEND_IDLE: begin
        idle_pct  = 78;
        stall_pct = 0;
      end
      PH_RECV_STALL: begin
        idle_pct  = 0;
        stall_pct = 78;
      end
      default: begin
        idle_pct  = 20;
        stall_pct = 20;
      end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_char(input logic [7:0] ch, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_in   <= ch;
    in_final_req <= fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  task automatic append_char(input logic [7:0] c);
    text_q = {text_q, c};
  endtask

  task automatic push_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      append_char(s[i]);
    end
  endtask

  function automatic logic [7:0] alpha_char();
    return alphabet[$urandom_range(63)];
  endfunction

  task automatic random_text();
    int kind;
    int groups;
    int pads;
    int len;
    int g;
    int j;
    int pos;
    kind   = $urandom_range(99);
    groups = ($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
    pads   = $urandom_range(2);
    if (kind < 85) begin
      for (g = 0; g < groups; g++) begin
        for (j = 0; j < 4; j++) begin
          if (g == groups - 1 && j >= 4 - pads) append_char(PAD_CHAR);
          else append_char(alpha_char());
        end
      end
      // broken texts: one character replaced, or the length cut short
      if (kind >= 70) begin
        pos = $urandom_range(text_q.size() - 1);
        case ($urandom_range(2))
          0: text_q[pos] = 8'($urandom_range(255));
          1: text_q[pos] = PAD_CHAR;
          default: void'(text_q.pop_back());
        endcase
        if (text_q.size() == 0) append_char(alpha_char());
      end
    end else begin
      len = $urandom_range(1, 9);
      for (j = 0; j < len; j++) begin
        case ($urandom_range(3))
          0: append_char(8'($urandom_range(255)));
          1: append_char(PAD_CHAR);
          default: append_char(alpha_char());
        endcase
      end
    end
    send_text();
  endtask

  initial begin
    int p;
    set_phase(PH_FREE);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // alphabet extremes, two and one byte tails, length, character and padding errors
    push_str("AZaz09+/");
    send_text();
    push_str("QUI=");
    send_text();
    push_str("QQ==");
    send_text();
    push_str("A");
    send_text();
    push_str("A");
    append_char(8'hFF);
    push_str("B");
    send_text();
    push_str("A=BC");
    send_text();
    push_str("A===");
    send_text();

    hold_go <= 1'b1;
    for (p = 0; p < 5; p++) begin
      set_phase(idle_phase_t'(p % 4));
      while (sent_count < TEXT_ITEMS * (p + 1) / 5) random_text();
    end
    in_valid <= 1'b0;
    set_phase(PH_FREE);

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ base64_decoder_checked.f @@
+incdir+hw/rtl
hw/rtl/b64_pkg.sv
hw/rtl/b64_front.sv
hw/rtl/b64_queue.sv
hw/rtl/b64_back.sv
hw/rtl/base64_decoder_checked.sv
dv/b64_decode_checker.sv
dv/testbench.sv
